@@ hw/rtl/bps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the BPS patch body decoder.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_SIZE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_SIZE = 2'd1;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_PATCH  = 2'd1;
   localparam logic [1:0] FUNC_PULL   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] CMD_SOURCE_READ = 2'd0;
   localparam logic [1:0] CMD_TARGET_READ = 2'd1;
   localparam logic [1:0] CMD_SOURCE_COPY = 2'd2;
   localparam logic [1:0] CMD_TARGET_COPY = 2'd3;

   localparam logic [7:0] VARINT_DATA_MASK = 8'h7F;
   localparam logic [7:0] VARINT_STOP_FLAG = 8'h80;

   // weight index at which 128^k no longer fits in 64 bits
   localparam logic [3:0] WEIGHT_GONE = 4'd10;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_OFS,
      PH_LIT,
      PH_RUN
   } phase_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_LITERAL,
      SEL_SOURCE,
      SEL_TARGET
   } byte_sel_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  byte_value;
      logic [15:0] load_address;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]  target_byte;
      logic [15:0] target_position;
      logic        was_filled;
      logic        is_last;
   } rsp_beat_type;

endpackage

@@ hw/rtl/bps_patch_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_patch_decoder
// Streaming BPS patch body decoder with source and target byte stores.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write target_size (index 0) and source_size (index 1) while idle.
//   req_*  : func 0 loads a source byte at load_address, func 1 feeds one
//            patch body byte, func 2 pulls the next byte of a pending run.
//   rsp_*  : one reconstructed target byte per emitting request.
// A request is decoded in the decode stage as it is taken; its result then
// passes the store read stage and the output register before it appears on
// rsp_*. One request is taken per cycle as long as the result side keeps up;
// the single read port of each store and the output register set that figure.
// A TargetCopy that reads the byte just produced is served by forwarding from
// the write-back.
// Reset (synchronous) clears the decoder state and the pipeline valid bits;
// store contents are undefined until written. When rsp_stall holds, the
// output register keeps its beat, the read stage fills and then req_stall
// rises until the output register drains.
// ----------------------------------------------------------------------------
module bps_patch_decoder #(
   parameter int ADDR_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bps_pkg::req_beat_type                  req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bps_pkg::rsp_beat_type                  rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bps_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import bps_pkg::*;

   localparam int DEPTH = 2 ** ADDR_BITS;

   // configuration
   logic [16:0] target_size_ff, source_size_ff;

   // decoder state
   phase_type   phase_ff, phase_in;
   logic [1:0]  pend_cmd_ff, pend_cmd_in;
   logic [16:0] count_ff, count_in;
   logic [16:0] run_ff, run_in;
   logic [31:0] src_cur_ff, src_cur_in;
   logic [31:0] tgt_cur_ff, tgt_cur_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  wsh_ff, wsh_in;

   // read stage
   logic                 b_valid_ff;
   byte_sel_type         b_sel_ff;
   logic [7:0]           b_lit_ff;
   logic [15:0]          b_pos_ff;
   logic                 b_filled_ff, b_last_ff;
   logic [ADDR_BITS-1:0] b_waddr_ff;
   logic                 b_fwd_ff;
   logic [7:0]           b_fwd_byte_ff;

   // output register
   logic         o_valid_ff;
   rsp_beat_type o_data_ff;

   // stores
   logic [7:0] src_mem [DEPTH];
   logic [7:0] tgt_mem [DEPTH];
   logic [7:0] src_rd_ff, tgt_rd_ff;

   logic o_take, b_move, accept;
   logic [7:0] b_byte;

   assign csr_ready = 1'b1;
   assign o_take    = !o_valid_ff || !rsp_stall;
   assign b_move    = b_valid_ff && o_take;
   assign req_stall = b_valid_ff && !o_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (b_sel_ff)
         SEL_LITERAL: b_byte = b_lit_ff;
         SEL_SOURCE:  b_byte = src_rd_ff;
         SEL_TARGET:  b_byte = b_fwd_ff ? b_fwd_byte_ff : tgt_rd_ff;
         default:     b_byte = 8'd0;
      endcase
   end

   // ---------------- varint step ----------------
   logic [63:0] vi_term, vi_sum, vi_next_w;
   logic [3:0]  vi_next_sh;
   logic        vi_done;
   logic [6:0]  vi_bits;

   always_comb begin
      vi_bits    = req_data.byte_value[6:0] & VARINT_DATA_MASK[6:0];
      vi_done    = (req_data.byte_value & VARINT_STOP_FLAG) != 8'd0;
      vi_term    = (wsh_ff < WEIGHT_GONE)
                   ? (64'(vi_bits) << (7'(wsh_ff) * 7'd7)) : 64'd0;
      vi_sum     = acc_ff + vi_term;
      vi_next_sh = (wsh_ff < WEIGHT_GONE) ? wsh_ff + 4'd1 : WEIGHT_GONE;
      vi_next_w  = (vi_next_sh < WEIGHT_GONE)
                   ? (64'd1 << (7'(vi_next_sh) * 7'd7)) : 64'd0;
   end

   // ---------------- emit decision (outputs) ----------------
   logic         active, emit;
   byte_sel_type e_sel;
   logic         e_filled, e_last;
   logic [31:0]  rd_pos, cnt32;
   logic         src_ok;
   logic [17:0]  cnt_inc;

   always_comb begin
      cnt32    = 32'(count_ff);
      cnt_inc  = {1'b0, count_ff} + 18'd1;
      active   = (req_data.func == FUNC_PATCH || req_data.func == FUNC_PULL)
                 && (count_ff < target_size_ff);
      rd_pos   = (pend_cmd_ff == CMD_SOURCE_READ) ? cnt32 : src_cur_ff;
      src_ok   = (rd_pos < 32'(source_size_ff)) && ((rd_pos >> ADDR_BITS) == 32'd0);
      emit     = 1'b0;
      e_sel    = SEL_ZERO;
      e_filled = 1'b0;
      if (active && req_data.func == FUNC_PATCH && phase_ff == PH_LIT) begin
         emit     = 1'b1;
         e_sel    = SEL_LITERAL;
         e_filled = 1'b1;
      end else if (active && req_data.func == FUNC_PULL && phase_ff == PH_RUN
                   && run_ff != 17'd0) begin
         emit = 1'b1;
         if (pend_cmd_ff == CMD_TARGET_COPY) begin
            e_filled = tgt_cur_ff < cnt32;
            e_sel    = e_filled ? SEL_TARGET : SEL_ZERO;
         end else begin
            e_filled = src_ok;
            e_sel    = src_ok ? SEL_SOURCE : SEL_ZERO;
         end
      end
      e_last = cnt_inc == {1'b0, target_size_ff};
   end

   // ---------------- next state ----------------
   logic [17:0] len;
   logic [16:0] room;
   logic [31:0] mag;
   logic [16:0] run_dec;

   always_comb begin
      phase_in    = phase_ff;
      pend_cmd_in = pend_cmd_ff;
      count_in    = count_ff;
      run_in      = run_ff;
      src_cur_in  = src_cur_ff;
      tgt_cur_in  = tgt_cur_ff;
      acc_in      = acc_ff;
      wsh_in      = wsh_ff;
      len         = {1'b0, vi_sum[18:2]} + 18'd1;
      room        = target_size_ff - count_ff;
      mag         = vi_sum[32:1];
      run_dec     = (run_ff != 17'd0) ? run_ff - 17'd1 : 17'd0;
      if (accept && emit) begin
         count_in = cnt_inc[16:0];
         run_in   = run_dec;
         if (run_dec == 17'd0 || cnt_inc >= {1'b0, target_size_ff}) begin
            run_in   = 17'd0;
            phase_in = PH_CMD;
         end
         if (e_sel == SEL_SOURCE || (e_sel == SEL_ZERO && phase_ff == PH_RUN)) begin
            if (pend_cmd_ff == CMD_SOURCE_COPY) src_cur_in = src_cur_ff + 32'd1;
         end
         if (phase_ff == PH_RUN && pend_cmd_ff == CMD_TARGET_COPY)
            tgt_cur_in = tgt_cur_ff + 32'd1;
      end else if (accept && active && req_data.func == FUNC_PATCH
                   && (phase_ff == PH_CMD || phase_ff == PH_OFS)) begin
         if (vi_done) begin
            acc_in = 64'd0;
            wsh_in = 4'd0;
            if (phase_ff == PH_CMD) begin
               pend_cmd_in = vi_sum[1:0];
               if (vi_sum[63:19] != 45'd0 || len >= {1'b0, room})
                  run_in = room;
               else
                  run_in = len[16:0];
               case (vi_sum[1:0])
                  CMD_SOURCE_READ: phase_in = PH_RUN;
                  CMD_TARGET_READ: phase_in = PH_LIT;
                  default:         phase_in = PH_OFS;
               endcase
            end else begin
               if (pend_cmd_ff == CMD_SOURCE_COPY)
                  src_cur_in = vi_sum[0] ? src_cur_ff - mag : src_cur_ff + mag;
               else
                  tgt_cur_in = vi_sum[0] ? tgt_cur_ff - mag : tgt_cur_ff + mag;
               phase_in = PH_RUN;
            end
         end else begin
            acc_in = vi_sum + vi_next_w;
            wsh_in = vi_next_sh;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         target_size_ff <= '0;
         source_size_ff <= '0;
         phase_ff       <= PH_CMD;
         pend_cmd_ff    <= CMD_SOURCE_READ;
         count_ff       <= '0;
         run_ff         <= '0;
         src_cur_ff     <= '0;
         tgt_cur_ff     <= '0;
         acc_ff         <= '0;
         wsh_ff         <= '0;
         b_valid_ff     <= 1'b0;
         o_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TARGET_SIZE) target_size_ff <= csr_wdata;
            else if (csr_index == CSR_SOURCE_SIZE) source_size_ff <= csr_wdata;
         end
         phase_ff    <= phase_in;
         pend_cmd_ff <= pend_cmd_in;
         count_ff    <= count_in;
         run_ff      <= run_in;
         src_cur_ff  <= src_cur_in;
         tgt_cur_ff  <= tgt_cur_in;
         acc_ff      <= acc_in;
         wsh_ff      <= wsh_in;
         if (accept) b_valid_ff <= emit;
         else if (b_move) b_valid_ff <= 1'b0;
         if (b_move) o_valid_ff <= 1'b1;
         else if (!rsp_stall) o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_sel_ff      <= e_sel;
         b_lit_ff      <= req_data.byte_value;
         b_pos_ff      <= count_ff[15:0];
         b_filled_ff   <= e_filled;
         b_last_ff     <= e_last;
         b_waddr_ff    <= cnt32[ADDR_BITS-1:0];
         // byte written back this cycle is not yet visible in the store
         b_fwd_ff      <= b_move && (tgt_cur_ff[ADDR_BITS-1:0] == b_waddr_ff);
         b_fwd_byte_ff <= b_byte;
      end
      if (b_move) begin
         o_data_ff.target_byte     <= b_byte;
         o_data_ff.target_position <= b_pos_ff;
         o_data_ff.was_filled      <= b_filled_ff;
         o_data_ff.is_last         <= b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.func == FUNC_LOAD)
         src_mem[ADDR_BITS'(req_data.load_address)] <= req_data.byte_value;
      if (accept && e_sel == SEL_SOURCE)
         src_rd_ff <= src_mem[rd_pos[ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (b_move)
         tgt_mem[b_waddr_ff] <= b_byte;
      if (accept && e_sel == SEL_TARGET)
         tgt_rd_ff <= tgt_mem[tgt_cur_ff[ADDR_BITS-1:0]];
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule

@@ hw/rtl/bps_patch_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_patch_decoder_checker
// Port-level checks on the patch decoder, bound into every decoder instance.
// ----------------------------------------------------------------------------
module bps_patch_decoder_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input bps_pkg::rsp_beat_type rsp_data,
   input logic                  csr_ready
);
   import bps_pkg::*;

   ast_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   ast_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   ast_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_filled |-> rsp_data.target_byte == 8'd0)
      else $error("unfilled byte is not zero");

   ast_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind bps_patch_decoder bps_patch_decoder_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

@@ sim/bps_patch_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_patch_decoder_tb
// Self-checking bench for the BPS patch body decoder. A directed table walks
// each command type, out-of-range reads and ignored beats. Random well-formed
// command streams with some noise follow, under three idling regimes. Every
// result beat is compared with its table entry or a behavioral predictor.
// ----------------------------------------------------------------------------
module bps_patch_decoder_tb;
   import bps_pkg::*;

   localparam int LIMIT = 1_000_000;
   localparam int DEPTH = 65536;

   typedef struct {
      logic [1:0]   f;
      logic [7:0]   b;
      logic [15:0]  a;
      bit           typed;
      rsp_beat_type r;
   } dir_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_beat_type rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   bps_patch_decoder dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // predictor state
   logic [7:0]  src_mem [DEPTH];
   logic [7:0]  tgt_mem [DEPTH];
   bit          src_written [DEPTH];
   logic [16:0] tgt_size, src_size;
   int unsigned out_count, src_cur, tgt_cur, run_left;
   longint unsigned vi_acc, vi_weight;
   phase_type   phase;
   logic [1:0]  pend_cmd;

   rsp_beat_type expected_q[$];
   dir_row_type  rows[$];
   int errors = 0, cycles = 0, results_seen = 0, items_sent = 0;
   int snd_idle = 0, rcv_idle = 0;

   function automatic void queue_expected(rsp_beat_type r);
      expected_q = {expected_q, r};
   endfunction

   function automatic void add_row(dir_row_type r);
      rows = {rows, r};
   endfunction

   function automatic rsp_beat_type emit_byte(logic [7:0] b, bit filled);
      rsp_beat_type r;
      tgt_mem[out_count[15:0]] = b;
      r.target_byte = b;
      r.target_position = out_count[15:0];
      r.was_filled = filled;
      out_count++;
      r.is_last = (out_count == tgt_size);
      if (run_left > 0) run_left--;
      if (run_left == 0 || out_count >= tgt_size) begin
         run_left = 0;
         phase = PH_CMD;
      end
      return r;
   endfunction

   function automatic bit feed_varint(logic [7:0] b, output longint unsigned v);
      vi_acc += longint'(b & VARINT_DATA_MASK) * vi_weight;
      if ((b & VARINT_STOP_FLAG) != 0) begin
         v = vi_acc;
         vi_acc = 0;
         vi_weight = 1;
         return 1;
      end
      vi_weight <<= 7;
      vi_acc += vi_weight;
      return 0;
   endfunction

   function automatic int unsigned offset_cursor(int unsigned c, longint unsigned v);
      int unsigned mag;
      mag = v[32:1];
      return v[0] ? c - mag : c + mag;
   endfunction

   // returns 1 when the beat produces a target byte
   function automatic bit decode_beat(req_beat_type q, output rsp_beat_type r);
      longint unsigned v, len, room;
      int unsigned p;
      r = '0;
      if (q.func == FUNC_LOAD) begin
         src_mem[q.load_address] = q.byte_value;
         src_written[q.load_address] = 1;
         return 0;
      end
      if (q.func == FUNC_UNUSED || out_count >= tgt_size) return 0;
      if (q.func == FUNC_PATCH) begin
         if (phase == PH_LIT) begin
            r = emit_byte(q.byte_value, 1);
            return 1;
         end
         if (phase == PH_CMD && feed_varint(q.byte_value, v)) begin
            len = (v >> 2) + 1;
            room = tgt_size - out_count;
            run_left = 32'((len < room) ? len : room);
            pend_cmd = v[1:0];
            if (pend_cmd == CMD_SOURCE_READ) phase = PH_RUN;
            else if (pend_cmd == CMD_TARGET_READ) phase = PH_LIT;
            else phase = PH_OFS;
         end else if (phase == PH_OFS && feed_varint(q.byte_value, v)) begin
            if (pend_cmd == CMD_SOURCE_COPY) src_cur = offset_cursor(src_cur, v);
            else tgt_cur = offset_cursor(tgt_cur, v);
            phase = PH_RUN;
         end
         return 0;
      end
      if (phase != PH_RUN || run_left == 0) return 0;
      if (pend_cmd == CMD_TARGET_COPY) begin
         p = tgt_cur;
         tgt_cur++;
         r = (p < out_count) ? emit_byte(tgt_mem[p[15:0]], 1) : emit_byte(8'h00, 0);
         return 1;
      end
      if (pend_cmd == CMD_SOURCE_READ) p = out_count;
      else begin
         p = src_cur;
         src_cur++;
      end
      r = (p < src_size && p < DEPTH) ? emit_byte(src_mem[p[15:0]], 1)
                                      : emit_byte(8'h00, 0);
      return 1;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rcv_idle);

   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (e.target_byte !== rsp_data.target_byte)
               $display("%0t: target_byte exp %h got %h", $time, e.target_byte,
                        rsp_data.target_byte);
            if (e.target_position !== rsp_data.target_position)
               $display("%0t: target_position exp %h got %h", $time,
                        e.target_position, rsp_data.target_position);
            if (e.was_filled !== rsp_data.was_filled)
               $display("%0t: was_filled exp %b got %b", $time, e.was_filled,
                        rsp_data.was_filled);
            if (e.is_last !== rsp_data.is_last)
               $display("%0t: is_last exp %b got %b", $time, e.is_last,
                        rsp_data.is_last);
            if (e !== rsp_data) errors++;
         end
      end
   end

   task automatic send_beat(req_beat_type q, bit typed = 0, rsp_beat_type tr = '0);
      rsp_beat_type r;
      bit hit;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      hit = decode_beat(q, r);
      if (typed) queue_expected(tr);
      else if (hit) queue_expected(r);
      items_sent++;
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(logic [1:0] f, logic [7:0] b);
      req_beat_type q;
      q.func = f;
      q.byte_value = b;
      q.load_address = 16'($urandom_range(16'hFFFF));
      send_beat(q);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [16:0] val);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_TARGET_SIZE) tgt_size = val;
      else src_size = val;
   endtask

   task automatic load_below(int n);
      req_beat_type q;
      for (int a = 0; a < n; a++)
         if (!src_written[a]) begin
            q.func = FUNC_LOAD;
            q.byte_value = 8'($urandom_range(255));
            q.load_address = 16'(a);
            send_beat(q);
         end
   endtask

   task automatic send_varint(longint unsigned v);
      while (1) begin
         if ((v >> 7) == 0) begin
            send_fields(FUNC_PATCH, v[6:0] | VARINT_STOP_FLAG);
            break;
         end
         send_fields(FUNC_PATCH, {1'b0, v[6:0]});
         v = (v >> 7) - 1;
      end
   endtask

   // bring the decoder back to a command boundary after noise
   task automatic resync;
      while (out_count < tgt_size && !(phase == PH_CMD && vi_weight == 1)) begin
         case (phase)
            PH_LIT: begin
               send_fields(FUNC_PATCH, 8'($urandom_range(255)));
            end
            PH_RUN: begin
               send_fields(FUNC_PULL, 8'($urandom_range(255)));
            end
            default: begin
               send_fields(FUNC_PATCH, VARINT_STOP_FLAG | 8'($urandom_range(127)));
            end
         endcase
      end
   endtask

   task automatic random_command;
      logic [1:0] cmd;
      int unsigned len, dest, delta, mag;
      cmd = 2'($urandom_range(3));
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 60);
      send_varint(longint'(len - 1) << 2 | cmd);
      if (cmd == CMD_SOURCE_COPY || cmd == CMD_TARGET_COPY) begin
         if (cmd == CMD_SOURCE_COPY)
            dest = ($urandom_range(9) != 0 && src_size != 0) ? $urandom_range(src_size - 1)
                                                            : src_size + $urandom_range(20);
         else
            dest = ($urandom_range(9) != 0 && out_count != 0) ? $urandom_range(out_count - 1)
                                                             : out_count + $urandom_range(5);
         if ($urandom_range(49) == 0) dest = $urandom;   // far away, cursor wraps
         delta = dest - ((cmd == CMD_SOURCE_COPY) ? src_cur : tgt_cur);
         if ($signed(delta) < 0) begin
            mag = -delta;
            send_varint((longint'(mag) << 1) | 64'd1);
         end else begin
            send_varint(longint'(delta) << 1);
         end
      end
      while (out_count < tgt_size && (phase == PH_LIT || phase == PH_RUN)) begin
         if (phase == PH_RUN && $urandom_range(19) == 0)
            send_fields(FUNC_PATCH, 8'($urandom_range(255)));   // ignored during a run
         else
            send_fields(phase == PH_LIT ? FUNC_PATCH : FUNC_PULL, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      int snd_pct[3] = '{16, 88, 0};
      int rcv_pct[3] = '{88, 16, 0};
      int src_sizes[3] = '{16, 64, 128};
      int start, n;
      req_beat_type q;

      tgt_size = 0; src_size = 0; out_count = 0; src_cur = 0; tgt_cur = 0;
      run_left = 0; vi_acc = 0; vi_weight = 1; phase = PH_CMD; pend_cmd = CMD_SOURCE_READ;
      foreach (src_written[i]) src_written[i] = 0;

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // nothing to produce yet: ignored
      send_fields(FUNC_PATCH, 8'h81);
      drain();
      csr_write(CSR_TARGET_SIZE, 17'd8);
      csr_write(CSR_SOURCE_SIZE, 17'd4);

      add_row('{FUNC_LOAD,   8'hA5, 16'h0000, 0, '0});
      add_row('{FUNC_LOAD,   8'hFF, 16'h0001, 0, '0});
      add_row('{FUNC_LOAD,   8'h00, 16'h0002, 0, '0});
      add_row('{FUNC_LOAD,   8'h5A, 16'h0003, 0, '0});
      add_row('{FUNC_LOAD,   8'h3C, 16'hFFFF, 0, '0});
      add_row('{FUNC_PATCH,  8'h84, 16'h0000, 0, '0});   // SourceRead x2
      add_row('{FUNC_PATCH,  8'h11, 16'hFFFF, 0, '0});   // dropped, run pending
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'hA5, 16'd0, 1'b1, 1'b0}});
      add_row('{FUNC_PULL,   8'hFF, 16'h0000, 1, '{8'hFF, 16'd1, 1'b1, 1'b0}});
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 0, '0});   // no run
      add_row('{FUNC_PATCH,  8'h81, 16'h0000, 0, '0});   // TargetRead x1
      add_row('{FUNC_PATCH,  8'h77, 16'h0000, 1, '{8'h77, 16'd2, 1'b1, 1'b0}});
      add_row('{FUNC_PATCH,  8'h86, 16'h0000, 0, '0});   // SourceCopy x2
      add_row('{FUNC_PATCH,  8'h84, 16'h0000, 0, '0});   // +2
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'h00, 16'd3, 1'b1, 1'b0}});
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'h5A, 16'd4, 1'b1, 1'b0}});
      add_row('{FUNC_PATCH,  8'h82, 16'h0000, 0, '0});   // SourceCopy x1
      add_row('{FUNC_PATCH,  8'h80, 16'h0000, 0, '0});   // +0, past source end
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'h00, 16'd5, 1'b0, 1'b0}});
      add_row('{FUNC_PATCH,  8'h87, 16'h0000, 0, '0});   // TargetCopy x2
      add_row('{FUNC_PATCH,  8'h80, 16'h0000, 0, '0});
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'hA5, 16'd6, 1'b1, 1'b0}});
      add_row('{FUNC_PULL,   8'h00, 16'h0000, 1, '{8'hFF, 16'd7, 1'b1, 1'b1}});
      add_row('{FUNC_PATCH,  8'h81, 16'h0000, 0, '0});   // target complete
      add_row('{FUNC_UNUSED, 8'hFF, 16'hFFFF, 0, '0});   // unused func
      foreach (rows[i]) begin
         q.func = rows[i].f;
         q.byte_value = rows[i].b;
         q.load_address = rows[i].a;
         send_beat(q, rows[i].typed, rows[i].r);
      end

      for (int p = 0; p < 3; p++) begin
         drain();
         snd_idle = snd_pct[p];
         rcv_idle = rcv_pct[p];
         if (p == 2) begin
            // lowered below the count: everything is dropped
            csr_write(CSR_TARGET_SIZE, 17'(out_count - 3));
            repeat (10) send_fields(2'($urandom_range(1, 2)), 8'($urandom_range(255)));
            drain();
         end
         csr_write(CSR_SOURCE_SIZE, 17'(src_sizes[p]));
         load_below(src_sizes[p]);
         n = out_count + 620;
         csr_write(CSR_TARGET_SIZE, 17'((p == 2 || n > DEPTH) ? DEPTH : n));
         resync();
         start = items_sent;
         while (items_sent - start < 580) begin
            if ($urandom_range(9) == 0) begin
               send_fields(2'($urandom_range(3)), 8'($urandom_range(255)));
               resync();
            end else if (out_count < tgt_size) random_command();
            else send_fields(2'($urandom_range(1, 2)), 8'($urandom_range(255)));
         end
      end

      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d request beats driven, %0d target bytes checked", items_sent,
               results_seen);
      $display("three idle regimes, source sizes up to 128, target size up to 65536");
      if (errors == 0 && expected_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/bps_pkg.sv
hw/rtl/bps_patch_decoder.sv
hw/rtl/bps_patch_decoder_checker.sv
sim/bps_patch_decoder_tb.sv
